// ===== design/lsws_pkg.sv =====
// Shared types and constants for the longest subsequence word selector.
`timescale 1ns / 1ps
package lsws_pkg;

   // Longest run of result words per query
   localparam int MAX_RESULTS = 32;

   // Request mode codes
   localparam logic [1:0] MODE_REF  = 2'd0;
   localparam logic [1:0] MODE_CAND = 2'd1;
   localparam logic [1:0] MODE_EMIT = 2'd2;

   // Order of the candidate prefix against the best word
   typedef enum logic [1:0] {
      ORD_EQUAL   = 2'd0,
      ORD_LESS    = 2'd1,
      ORD_GREATER = 2'd2
   } order_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_SCAN,
      ST_FINISH,
      ST_EMIT_RD,
      ST_EMIT_WR
   } state_type;

endpackage

// ===== design/lsws_ram.sv =====
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
module lsws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word when no read is issued
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/longest_subsequence_word_select_top.sv =====
// Top level of the longest subsequence word selector.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+------------------------------------------
//  req_    | in        | req_valid / req_ready | mode, char_in, first_char, last_char
//  rsp_    | out       | rsp_valid / rsp_ready | found, char_out, run_end, overflow_seen
//
//  A reference word is stored while the block stays in ST_IDLE. A candidate word passes
//  ST_CMP, then ST_SCAN, which reads one reference entry at a time: the scan is bound by
//  the one read port of the reference memory; then ST_FINISH. A candidate word of an
//  already failed word skips ST_SCAN, a dropped overlong one goes straight to ST_FINISH.
//  A query passes ST_EMIT_RD, then ST_EMIT_WR per word, waiting there while rsp_ready is low.
//  Synchronous reset clears all control state; memories need no clearing pass.
//  A finished result waits in the output register while the next request is taken;
//  only a new query stalls on a full output register.
//
module longest_subsequence_word_select_top
   import lsws_pkg::*;
#(
   parameter int MAX_REFERENCE = 1024,
   parameter int MAX_WORD = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_char_in,
   input  logic       req_first_char,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic [7:0] rsp_char_out,
   output logic       rsp_run_end,
   output logic       rsp_overflow_seen
);

   // Reference length/pointer width, reference address width
   localparam int RL_W = $clog2(MAX_REFERENCE + 1);
   localparam int RA_W = (MAX_REFERENCE > 1) ? $clog2(MAX_REFERENCE) : 1;
   // Word length width, word index width, word memory address (bank bit on top)
   localparam int WL_W = $clog2(MAX_WORD + 1);
   localparam int IDX_W = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int WA_W = IDX_W + 1;
   localparam int WDEPTH = 2 ** WA_W;

   state_type state_ff, state_in;

   // Reference state
   logic [RL_W-1:0] ref_len_ff, ref_len_in;
   logic [RL_W-1:0] match_pos_ff, match_pos_in;

   // Candidate state
   logic [WL_W-1:0] cand_len_ff, cand_len_in;
   logic            failed_ff, failed_in;
   order_type       order_ff, order_in;

   // Best word: lives in the word memory bank picked by best_bank_ff
   logic [WL_W-1:0] best_len_ff, best_len_in;
   logic            best_valid_ff, best_valid_in;
   logic            best_bank_ff, best_bank_in;
   logic            overflow_ff, overflow_in;

   // Scan pointers
   logic [RL_W-1:0] scan_addr_ff, scan_addr_in;
   logic [RL_W-1:0] data_addr_ff, data_addr_in;
   logic            pend_ff, pend_in;

   // Latched request fields
   logic [7:0]      char_ff, char_in;
   logic            last_ff, last_in;

   // Emission counter
   logic [WL_W-1:0] emit_cnt_ff, emit_cnt_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            found_ff, found_in;
   logic [7:0]      out_char_ff, out_char_in;
   logic            run_end_ff, run_end_in;
   logic            ovf_out_ff, ovf_out_in;

   // Memory ports
   logic            ref_wr_en, ref_rd_en;
   logic [RA_W-1:0] ref_wr_addr, ref_rd_addr;
   logic [7:0]      ref_rd_data;
   logic            word_wr_en, word_rd_en;
   logic [WA_W-1:0] word_wr_addr, word_rd_addr;
   logic [7:0]      word_rd_data;

   logic            accept, out_free, hit, better, have_best;
   logic [WL_W-1:0] emit_lim;

   lsws_ram #(
      .WIDTH(8),
      .DEPTH(MAX_REFERENCE)
   ) u_ref_ram (
      .clock  (clock),
      .wr_en  (ref_wr_en),
      .wr_addr(ref_wr_addr),
      .wr_data(req_char_in),
      .rd_en  (ref_rd_en),
      .rd_addr(ref_rd_addr),
      .rd_data(ref_rd_data)
   );

   // Two banks: the best word in one, the candidate being built in the other
   lsws_ram #(
      .WIDTH(8),
      .DEPTH(WDEPTH)
   ) u_word_ram (
      .clock  (clock),
      .wr_en  (word_wr_en),
      .wr_addr(word_wr_addr),
      .wr_data(req_char_in),
      .rd_en  (word_rd_en),
      .rd_addr(word_rd_addr),
      .rd_data(word_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hit = pend_ff && (ref_rd_data == char_ff);
   assign have_best = best_valid_ff && (best_len_ff != '0);
   assign emit_lim = (int'(best_len_ff) > MAX_RESULTS) ? WL_W'(MAX_RESULTS) : best_len_ff;
   // A passing candidate replaces the best when there is none, when longer, or equal and smaller
   assign better = !best_valid_ff || (cand_len_ff > best_len_ff) ||
                   ((cand_len_ff == best_len_ff) && (order_ff == ORD_LESS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ref_len_ff    <= '0;
         match_pos_ff  <= '0;
         cand_len_ff   <= '0;
         failed_ff     <= 1'b0;
         order_ff      <= ORD_EQUAL;
         best_len_ff   <= '0;
         best_valid_ff <= 1'b0;
         best_bank_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ref_len_ff    <= ref_len_in;
         match_pos_ff  <= match_pos_in;
         cand_len_ff   <= cand_len_in;
         failed_ff     <= failed_in;
         order_ff      <= order_in;
         best_len_ff   <= best_len_in;
         best_valid_ff <= best_valid_in;
         best_bank_ff  <= best_bank_in;
         overflow_ff   <= overflow_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      data_addr_ff <= data_addr_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      emit_cnt_ff  <= emit_cnt_in;
      found_ff     <= found_in;
      out_char_ff  <= out_char_in;
      run_end_ff   <= run_end_in;
      ovf_out_ff   <= ovf_out_in;
   end

   always_comb begin
      state_in      = state_ff;
      ref_len_in    = ref_len_ff;
      match_pos_in  = match_pos_ff;
      cand_len_in   = cand_len_ff;
      failed_in     = failed_ff;
      order_in      = order_ff;
      best_len_in   = best_len_ff;
      best_valid_in = best_valid_ff;
      best_bank_in  = best_bank_ff;
      overflow_in   = overflow_ff;
      scan_addr_in  = scan_addr_ff;
      data_addr_in  = data_addr_ff;
      pend_in       = 1'b0;
      char_in       = char_ff;
      last_in       = last_ff;
      emit_cnt_in   = emit_cnt_ff;
      found_in      = found_ff;
      out_char_in   = out_char_ff;
      run_end_in    = run_end_ff;
      ovf_out_in    = ovf_out_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      ref_wr_en    = 1'b0;
      ref_wr_addr  = ref_len_ff[RA_W-1:0];
      ref_rd_en    = 1'b0;
      ref_rd_addr  = scan_addr_ff[RA_W-1:0];
      word_wr_en   = 1'b0;
      word_wr_addr = {!best_bank_ff, cand_len_ff[IDX_W-1:0]};
      word_rd_en   = 1'b0;
      word_rd_addr = {best_bank_ff, cand_len_ff[IDX_W-1:0]};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               char_in = req_char_in;
               last_in = req_last_char;
               case (req_mode)
                  MODE_REF: begin
                     if (req_first_char) begin
                        // Drop reference, best word and any candidate in progress
                        best_len_in   = '0;
                        best_valid_in = 1'b0;
                        match_pos_in  = '0;
                        cand_len_in   = '0;
                        failed_in     = 1'b0;
                        order_in      = ORD_EQUAL;
                        ref_wr_en     = 1'b1;
                        ref_wr_addr   = '0;
                        ref_len_in    = RL_W'(1);
                        overflow_in   = 1'b0;
                     end else if (int'(ref_len_ff) < MAX_REFERENCE) begin
                        ref_wr_en  = 1'b1;
                        ref_len_in = ref_len_ff + 1'b1;
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  MODE_CAND: begin
                     if (int'(cand_len_ff) >= MAX_WORD) begin
                        // Too long: drop the character and reject the word
                        failed_in   = 1'b1;
                        overflow_in = 1'b1;
                        state_in    = ST_FINISH;
                     end else begin
                        // Store the character, fetch the best word's one alongside
                        word_wr_en = 1'b1;
                        word_rd_en = 1'b1;
                        state_in   = ST_CMP;
                     end
                  end
                  MODE_EMIT: begin
                     emit_cnt_in = '0;
                     state_in    = ST_EMIT_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_CMP: begin
            if ((order_ff == ORD_EQUAL) && best_valid_ff && (cand_len_ff < best_len_ff)) begin
               if (char_ff < word_rd_data) begin
                  order_in = ORD_LESS;
               end else if (char_ff > word_rd_data) begin
                  order_in = ORD_GREATER;
               end
            end
            cand_len_in = cand_len_ff + 1'b1;
            if (failed_ff) begin
               state_in = ST_FINISH;
            end else begin
               scan_addr_in = match_pos_ff;
               state_in     = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // One reference read a cycle; compare the word fetched the cycle before
            if (hit) begin
               match_pos_in = data_addr_ff + 1'b1;
               state_in     = ST_FINISH;
            end else if (scan_addr_ff < ref_len_ff) begin
               ref_rd_en    = 1'b1;
               data_addr_in = scan_addr_ff;
               pend_in      = 1'b1;
               scan_addr_in = scan_addr_ff + 1'b1;
            end else begin
               match_pos_in = ref_len_ff;
               failed_in    = 1'b1;
               state_in     = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (last_ff) begin
               if (!failed_ff && better) begin
                  // Swap banks: the candidate becomes the best word
                  best_len_in   = cand_len_ff;
                  best_valid_in = 1'b1;
                  best_bank_in  = !best_bank_ff;
               end
               match_pos_in = '0;
               cand_len_in  = '0;
               failed_in    = 1'b0;
               order_in     = ORD_EQUAL;
            end
            state_in = ST_IDLE;
         end

         ST_EMIT_RD: begin
            word_rd_en   = 1'b1;
            word_rd_addr = {best_bank_ff, emit_cnt_ff[IDX_W-1:0]};
            state_in     = ST_EMIT_WR;
         end

         ST_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               ovf_out_in   = overflow_ff;
               found_in     = have_best;
               if (have_best) begin
                  out_char_in = word_rd_data;
                  run_end_in  = ({1'b0, emit_cnt_ff} + 1'b1) == {1'b0, emit_lim};
               end else begin
                  out_char_in = '0;
                  run_end_in  = 1'b1;
               end
               if (!have_best || (({1'b0, emit_cnt_ff} + 1'b1) == {1'b0, emit_lim})) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_cnt_in = emit_cnt_ff + 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_char_out      = out_char_ff;
   assign rsp_run_end       = run_end_ff;
   assign rsp_overflow_seen = ovf_out_ff;

endmodule

// ===== verif/tb_longest_subsequence_word_select_top.sv =====
// Self-checking testbench for the longest subsequence word selector top level.
`timescale 1ns / 1ps
module tb_longest_subsequence_word_select_top
   import lsws_pkg::*;
();

   localparam int REF_DEPTH = 1024;
   localparam int WORD_DEPTH = 32;
   // Mode 3 has no meaning; the block must ignore it
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 130;

   // One result word as it leaves the rsp_ channel
   typedef struct packed {
      logic       found;
      logic [7:0] letter;
      logic       run_end;
      logic       overflow;
   } rsp_word_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_mode;
   logic [7:0] req_char_in;
   logic       req_first_char;
   logic       req_last_char;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_found;
   logic [7:0] rsp_char_out;
   logic       rsp_run_end;
   logic       rsp_overflow_seen;

   // Predicted selector state
   logic [7:0] ref_mem [REF_DEPTH];
   int         ref_len;
   int         scan_pos;
   logic [7:0] cand_mem [WORD_DEPTH];
   int         cand_len;
   logic       cand_failed;
   order_type  cand_order;
   logic [7:0] best_mem [WORD_DEPTH];
   int         best_len;
   logic       best_ok;
   logic       overflow_flag;

   // Result words still owed by the block, oldest first
   rsp_word_type owed_words [$];
   int           mismatch_count;

   // Traffic shaping: steady means no random idle on that side
   bit         req_steady;
   bit         rsp_steady;
   int         rsp_hold_cycles;

   longest_subsequence_word_select_top #(
      .MAX_REFERENCE(REF_DEPTH),
      .MAX_WORD(WORD_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode(req_mode),
      .req_char_in(req_char_in),
      .req_first_char(req_first_char),
      .req_last_char(req_last_char),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_found(rsp_found),
      .rsp_char_out(rsp_char_out),
      .rsp_run_end(rsp_run_end),
      .rsp_overflow_seen(rsp_overflow_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Drop any candidate in progress.
   task automatic clear_candidate();
      scan_pos = 0;
      cand_len = 0;
      cand_failed = 1'b0;
      cand_order = ORD_EQUAL;
   endtask

   // Advance the predicted state by one accepted request word and queue the
   // result words it owes.
   task automatic update_selection(input logic [1:0] mode, input logic [7:0] letter,
                                   input logic first_flag, input logic last_flag);
      int           pos;
      int           count;
      logic         better;
      rsp_word_type w;
      case (mode)
         MODE_REF: begin
            if (first_flag) begin
               ref_len = 0;
               best_len = 0;
               best_ok = 1'b0;
               overflow_flag = 1'b0;
               clear_candidate();
            end
            if (ref_len < REF_DEPTH) begin
               ref_mem[ref_len] = letter;
               ref_len++;
            end else begin
               overflow_flag = 1'b1;
            end
         end
         MODE_CAND: begin
            if (cand_len >= WORD_DEPTH) begin
               // Word buffer full: reject the whole candidate
               cand_failed = 1'b1;
               overflow_flag = 1'b1;
            end else begin
               if (!cand_failed) begin
                  // Walk the match pointer up to the next equal letter
                  pos = scan_pos;
                  while (pos < ref_len && ref_mem[pos] != letter) pos++;
                  if (pos < ref_len) begin
                     scan_pos = pos + 1;
                  end else begin
                     scan_pos = ref_len;
                     cand_failed = 1'b1;
                  end
               end
               // First differing letter decides the order against the best
               if (cand_order == ORD_EQUAL && best_ok && cand_len < best_len) begin
                  if (letter < best_mem[cand_len]) cand_order = ORD_LESS;
                  else if (letter > best_mem[cand_len]) cand_order = ORD_GREATER;
               end
               cand_mem[cand_len] = letter;
               cand_len++;
            end
            if (last_flag) begin
               if (!cand_failed) begin
                  better = !best_ok || cand_len > best_len ||
                           (cand_len == best_len && cand_order == ORD_LESS);
                  if (better) begin
                     for (int k = 0; k < cand_len; k++) best_mem[k] = cand_mem[k];
                     best_len = cand_len;
                     best_ok = 1'b1;
                  end
               end
               clear_candidate();
            end
         end
         MODE_EMIT: begin
            if (!best_ok || best_len == 0) begin
               w = '{found: 1'b0, letter: 8'h00, run_end: 1'b1, overflow: overflow_flag};
               owed_words = {owed_words, w};
            end else begin
               count = (best_len > MAX_RESULTS) ? MAX_RESULTS : best_len;
               for (int k = 0; k < count; k++) begin
                  w = '{found: 1'b1, letter: best_mem[k], run_end: (k == count - 1),
                        overflow: overflow_flag};
                  owed_words = {owed_words, w};
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Offer one request word and hold it until the block takes it. Called
   // and returns just after a falling edge; valid drops on return and the
   // next call raises it again in the same time step, so back-to-back words
   // need no gap.
   task automatic send_word(input logic [1:0] mode, input logic [7:0] letter,
                            input logic first_flag, input logic last_flag);
      if (!req_steady) begin
         while ($urandom_range(0, 99) < 26) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_char_in = letter;
      req_first_char = first_flag;
      req_last_char = last_flag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      update_selection(mode, letter, first_flag, last_flag);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // Send a text as a reference (first flag on its first letter) or as a
   // candidate (last flag on its last letter).
   task automatic send_text(input logic [1:0] mode, input string text);
      for (int i = 0; i < text.len(); i++)
         send_word(mode, text[i], mode == MODE_REF && i == 0,
                   mode == MODE_CAND && i == text.len() - 1);
   endtask

   task automatic send_query();
      send_word(MODE_EMIT, 8'h00, 1'b0, 1'b0);
   endtask

   // Wait until every owed result word has come back.
   task automatic wait_drained();
      while (owed_words.size() != 0) @(negedge clock);
   endtask

   // Lowercase letter from a small alphabet, or any byte when span is 256.
   function automatic logic [7:0] pick_letter(input int span);
      if (span >= 256) return 8'($urandom_range(0, 255));
      return 8'("a") + 8'($urandom_range(0, span - 1));
   endfunction

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------

   // Drive rsp_ready at the falling edge; a requested hold-off counts down
   // here, by one at each falling edge.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            rsp_hold_cycles--;
         end else if (rsp_steady) begin
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= 26);
         end
      end
   end

   // Compare each taken result word with the oldest owed one.
   always @(posedge clock) begin : check_rsp
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{found: rsp_found, letter: rsp_char_out, run_end: rsp_run_end,
                 overflow: rsp_overflow_seen};
         if (owed_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected rsp word found=%b char=%h end=%b ovf=%b",
                        $realtime, got.found, got.letter, got.run_end, got.overflow);
         end else begin
            want = owed_words.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: bad rsp word: exp found=%b char=%h end=%b ovf=%b, ",
                            "got found=%b char=%h end=%b ovf=%b"}, $realtime,
                           want.found, want.letter, want.run_end, want.overflow,
                           got.found, got.letter, got.run_end, got.overflow);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Query before anything is loaded, a candidate against an empty
   // reference, and the unused mode.
   task automatic test_empty_state();
      send_query();
      send_word(MODE_CAND, "x", 1'b0, 1'b1);
      send_word(MODE_UNUSED, 8'hFF, 1'b1, 1'b1);
      send_query();
   endtask

   // Classic case: longest subsequence wins, non-subsequences fail.
   task automatic test_basic_selection();
      send_text(MODE_REF, "abpcplea");
      send_text(MODE_CAND, "apple");
      send_text(MODE_CAND, "monkey");
      send_text(MODE_CAND, "plea");
      send_query();
   endtask

   // Equal lengths: smaller word replaces, a tie or a greater word does not.
   task automatic test_tie_order();
      send_text(MODE_REF, "abc");
      send_text(MODE_CAND, "b");
      send_text(MODE_CAND, "a");
      send_text(MODE_CAND, "a");
      send_text(MODE_CAND, "c");
      send_query();
   endtask

   // Byte extremes in reference and candidate.
   task automatic test_byte_extremes();
      send_word(MODE_REF, 8'hFF, 1'b1, 1'b0);
      send_word(MODE_REF, 8'h00, 1'b0, 1'b1);
      send_word(MODE_REF, 8'hFF, 1'b0, 1'b0);
      send_word(MODE_CAND, 8'hFF, 1'b1, 1'b0);
      send_word(MODE_CAND, 8'h00, 1'b0, 1'b1);
      send_word(MODE_CAND, 8'h00, 1'b0, 1'b0);
      send_word(MODE_CAND, 8'hFF, 1'b0, 1'b1);
      send_query();
   endtask

   // Full-length word gives the longest emission; one letter more overflows
   // the word buffer and is rejected.
   task automatic test_word_overflow();
      for (int i = 0; i < WORD_DEPTH; i++)
         send_word(MODE_REF, 8'h20 + 8'(i), i == 0, 1'b0);
      for (int i = 0; i < WORD_DEPTH; i++)
         send_word(MODE_CAND, 8'h20 + 8'(i), 1'b0, i == WORD_DEPTH - 1);
      send_query();
      for (int i = 0; i <= WORD_DEPTH; i++)
         send_word(MODE_CAND, 8'h20 + 8'(i % WORD_DEPTH), 1'b0, i == WORD_DEPTH);
      send_query();
   endtask

   // Fill the reference memory and push one letter past it; a candidate then
   // scans to the very last entry. Runs with no idling on either side.
   task automatic test_reference_overflow();
      req_steady = 1'b1;
      rsp_steady = 1'b1;
      for (int i = 0; i <= REF_DEPTH; i++)
         send_word(MODE_REF, (i == REF_DEPTH - 1) ? 8'("z") : 8'("a"), i == 0, 1'b0);
      send_text(MODE_CAND, "z");
      send_text(MODE_CAND, "q");
      send_query();
      wait_drained();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   // Hold the receiver off for a long stretch while queries keep coming, so
   // the output side fills and the request side stalls.
   task automatic test_output_stall();
      send_text(MODE_REF, "pressure");
      send_text(MODE_CAND, "press");
      @(posedge clock);
      rsp_hold_cycles = 300;
      @(negedge clock);
      for (int i = 0; i < 4; i++) send_query();
      send_text(MODE_CAND, "pressure");
      send_query();
   endtask

   // Random sessions: a reference, a handful of candidates (mostly real
   // subsequences, some random, some repeats), a query, with noise mixed in.
   task automatic test_random_traffic();
      logic [7:0] ref_text [$];
      logic [7:0] word [$];
      logic [7:0] prev_word [$];
      int         sent;
      int         span;
      int         len;
      int         pick;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         span = ($urandom_range(0, 99) < 20) ? 256 : $urandom_range(2, 6);
         len = $urandom_range(1, 20);
         ref_text.delete();
         prev_word.delete();
         for (int i = 0; i < len; i++) begin
            ref_text = {ref_text, pick_letter(span)};
            send_word(MODE_REF, ref_text[i], i == 0, 1'($urandom_range(0, 1)));
            sent++;
         end
         repeat ($urandom_range(1, 5)) begin
            word.delete();
            pick = $urandom_range(0, 99);
            if (pick < 10 && prev_word.size() != 0) begin
               word = prev_word;
            end else if (pick < 60) begin
               foreach (ref_text[k])
                  if ($urandom_range(0, 1) && word.size() < WORD_DEPTH)
                     word = {word, ref_text[k]};
               if (word.size() == 0)
                  word = {word, ref_text[$urandom_range(0, ref_text.size() - 1)]};
            end else if (pick < 65) begin
               // Candidate near the word buffer depth; overlong beyond 32 letters
               repeat ($urandom_range(30, 34)) word = {word, pick_letter(span)};
            end else begin
               repeat ($urandom_range(1, 8)) word = {word, pick_letter(span)};
            end
            foreach (word[k]) begin
               send_word(MODE_CAND, word[k], 1'($urandom_range(0, 1)),
                         k == word.size() - 1);
               sent++;
               if ($urandom_range(0, 99) < 5) begin
                  // Noise: unused mode, or a query in mid-word
                  if ($urandom_range(0, 1)) begin
                     send_word(MODE_UNUSED, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                  end else begin
                     send_query();
                     sent++;
                  end
               end
            end
            prev_word = word;
         end
         send_query();
         sent++;
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_REF;
      req_char_in = 8'h00;
      req_first_char = 1'b0;
      req_last_char = 1'b0;
      mismatch_count = 0;
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      rsp_hold_cycles = 0;
      ref_len = 0;
      best_len = 0;
      best_ok = 1'b0;
      overflow_flag = 1'b0;
      clear_candidate();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_state();
      test_basic_selection();
      test_tie_order();
      test_byte_extremes();
      test_word_overflow();
      test_reference_overflow();
      test_output_stall();
      test_random_traffic();

      // Drop valid, drain, then give stray words time to show up
      req_valid = 1'b0;
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && owed_words.size() == 0) begin
         $display("longest_subsequence_word_select_top: match");
      end else begin
         $display("longest_subsequence_word_select_top: mismatch");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("longest_subsequence_word_select_top: mismatch");
      $finish;
   end

endmodule
